// ===== rtl/core/rbb_pkg.sv =====
// Shared types and constants for the RGB 3x3 box blur.
package rbb_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int CFG_DW    = 12;
  localparam int CFG_IW    = 1;
  localparam int WREG_BITS = 11;
  localparam int HREG_BITS = 12;
  localparam int K_BITS    = 23;
  localparam int ROW_BITS  = 12;

  localparam logic [CFG_IW-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic [WREG_BITS-1:0] WIDTH_RST  = 11'd640;
  localparam logic [HREG_BITS-1:0] HEIGHT_RST = 12'd480;

  // sum of nine 8-bit samples, and floor(sum/9) as (sum*7282)>>16
  localparam int SUM_BITS    = 12;
  localparam int RECIP_BITS  = 13;
  localparam int MEAN_RECIP  = 7282;
  localparam int MEAN_SHIFT  = 16;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rbb_pix_t;

  typedef struct packed {
    logic emit;
    logic inner;
    logic last;
  } rbb_cls_t;

  typedef enum logic [1:0] {
    RC_RUN,
    RC_LOAD,
    RC_DIV
  } rbb_rc_state_t;

  localparam int PIX_BITS = $bits(rbb_pix_t);
  localparam int CLS_BITS = $bits(rbb_cls_t);

endpackage

// ===== rtl/core/rbb_front.sv =====
// Front end: config registers, raster counters, item classification, position rederive.
module rbb_front import rbb_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int CB = $clog2(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_red_in,
  input  logic [7:0]        in_green_in,
  input  logic [7:0]        in_blue_in,
  input  logic              in_flush,
  input  logic              q_ready,
  output logic              push_valid,
  output logic [CB-1:0]     push_col,
  output rbb_pix_t          push_pix,
  output rbb_cls_t          push_cls
);

  localparam int WW       = $clog2(MAX_WIDTH + 1);
  localparam int TB       = WW + HREG_BITS;
  localparam int CW       = (K_BITS > TB + 1) ? K_BITS : TB + 1;
  localparam int CNT_BITS = $clog2(K_BITS);
  localparam int PR_CB    = ROW_BITS + 1;

  logic [WREG_BITS-1:0] width_r;
  logic [HREG_BITS-1:0] height_r;
  logic [TB-1:0]        total_r;
  logic [K_BITS-1:0]    k_r, k_nxt;
  logic [CB-1:0]        col_r, col_nxt;
  logic [CB-1:0]        pc_r, pc_nxt;
  logic [ROW_BITS-1:0]  pr_r, pr_nxt;

  rbb_rc_state_t        st_r, st_nxt;
  logic [CNT_BITS-1:0]  cnt_r;
  logic [K_BITS-1:0]    num_r;
  logic [WW-1:0]        rem_r;
  logic [ROW_BITS-1:0]  quo_r;
  logic                 small_r;

  logic [WW-1:0]        w_eff;
  logic [HREG_BITS-1:0] h_eff;
  logic [CW-1:0]        k_x, w1_x, total_x, lastk_x, p_x;
  logic [CB-1:0]        col_eff, col_next;
  logic [WW-1:0]        col_inc, pc_inc;
  logic                 emit, inner, last, wrap;
  logic                 run, div_load, div_step, div_done;
  logic                 acc;
  logic [WW:0]          trial;
  logic                 ge;
  logic [WW-1:0]        rem_step;
  logic [ROW_BITS-1:0]  quo_step;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
  end

  assign h_eff   = (height_r == '0) ? HREG_BITS'(1) : height_r;
  assign k_x     = CW'(k_r);
  assign w1_x    = CW'(w_eff) + CW'(1);
  assign total_x = CW'(total_r);
  assign lastk_x = CW'(total_r) + CW'(w_eff);
  assign p_x     = k_x - w1_x;

  assign emit = (k_x >= w1_x) && (k_x <= lastk_x);
  assign wrap = (k_x >= lastk_x);
  assign last = (k_x == lastk_x);

  assign col_eff  = (WW'(col_r) >= w_eff) ? '0 : col_r;
  assign col_inc  = WW'(col_eff) + WW'(1);
  assign col_next = (col_inc >= w_eff) ? '0 : CB'(col_inc);
  assign pc_inc   = WW'(pc_r) + WW'(1);

  assign inner = (pr_r != '0) && (PR_CB'(pr_r) + PR_CB'(2) <= PR_CB'(h_eff)) &&
                 (pc_r != '0) && ((WW+1)'(pc_r) + (WW+1)'(2) <= (WW+1)'(w_eff));

  // restoring divide step for rederiving output row/column from the item count
  assign trial    = {rem_r, num_r[K_BITS-1]};
  assign ge       = trial >= (WW+1)'(w_eff);
  assign rem_step = ge ? WW'(trial - (WW+1)'(w_eff)) : WW'(trial);
  assign quo_step = {quo_r[ROW_BITS-2:0], ge};

  always_comb begin
    case (st_r)
      RC_RUN:  st_nxt = RC_RUN;
      RC_LOAD: st_nxt = RC_DIV;
      RC_DIV:  st_nxt = (cnt_r == CNT_BITS'(K_BITS - 1)) ? RC_RUN : RC_DIV;
      default: st_nxt = RC_RUN;
    endcase
    if (cfg_we) begin
      st_nxt = RC_LOAD;
    end
  end

  always_comb begin
    run      = 1'b0;
    div_load = 1'b0;
    div_step = 1'b0;
    div_done = 1'b0;
    case (st_r)
      RC_RUN:  run = 1'b1;
      RC_LOAD: div_load = 1'b1;
      RC_DIV: begin
        div_step = 1'b1;
        div_done = (cnt_r == CNT_BITS'(K_BITS - 1));
      end
      default: run = 1'b0;
    endcase
  end

  assign in_ready   = run && q_ready;
  assign acc        = in_valid && in_ready;
  assign push_valid = acc;
  assign push_col   = col_eff;
  assign push_cls   = '{emit: emit, inner: inner, last: last};

  always_comb begin
    if ((k_x < total_x) && !in_flush) begin
      push_pix = '{red: in_red_in, green: in_green_in, blue: in_blue_in};
    end else begin
      push_pix = '0;
    end
  end

  always_comb begin
    k_nxt   = k_r;
    col_nxt = col_r;
    pr_nxt  = pr_r;
    pc_nxt  = pc_r;
    if (acc) begin
      if (wrap) begin
        k_nxt   = '0;
        col_nxt = '0;
        pr_nxt  = '0;
        pc_nxt  = '0;
      end else begin
        k_nxt   = k_r + K_BITS'(1);
        col_nxt = col_next;
        if (emit) begin
          if (pc_inc >= w_eff) begin
            pc_nxt = '0;
            pr_nxt = pr_r + ROW_BITS'(1);
          end else begin
            pc_nxt = CB'(pc_inc);
          end
        end
      end
    end else if (div_done) begin
      pr_nxt = small_r ? '0 : quo_step;
      pc_nxt = small_r ? '0 : CB'(rem_step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      st_r     <= RC_LOAD;
      k_r      <= '0;
      col_r    <= '0;
      pr_r     <= '0;
      pc_r     <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we && cfg_idx == CFG_IDX_WIDTH) begin
        width_r <= cfg_wdata[WREG_BITS-1:0];
      end
      if (cfg_we && cfg_idx == CFG_IDX_HEIGHT) begin
        height_r <= cfg_wdata[HREG_BITS-1:0];
      end
      st_r  <= st_nxt;
      k_r   <= k_nxt;
      col_r <= col_nxt;
      pr_r  <= pr_nxt;
      pc_r  <= pc_nxt;
      if (div_load) begin
        cnt_r <= '0;
      end else if (div_step) begin
        cnt_r <= cnt_r + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    total_r <= TB'(w_eff) * TB'(h_eff);
    if (div_load) begin
      num_r   <= K_BITS'(p_x);
      small_r <= (k_x < w1_x);
      rem_r   <= '0;
      quo_r   <= '0;
    end else if (div_step) begin
      num_r <= {num_r[K_BITS-2:0], 1'b0};
      rem_r <= rem_step;
      quo_r <= quo_step;
    end
  end

endmodule

// ===== rtl/core/rbb_queue.sv =====
// Small FIFO between the classifier and the filter pipeline.
module rbb_queue import rbb_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [NW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign push_ready = (cnt_r != NW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + NW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - NW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/rbb_back.sv =====
// Back end: line stores, 3x3 window, channel means and output register.
module rbb_back import rbb_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int CB = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [CB-1:0] q_col,
  input  rbb_pix_t      q_pix,
  input  rbb_cls_t      q_cls,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_red_out,
  output logic [7:0]    out_green_out,
  output logic [7:0]    out_blue_out,
  output logic          out_last_pixel
);

  rbb_pix_t older_row_r [MAX_WIDTH];
  rbb_pix_t newer_row_r [MAX_WIDTH];

  logic          adv, pop;

  logic          b_vld_r;
  logic [CB-1:0] b_col_r;
  rbb_pix_t      b_pix_r;
  rbb_cls_t      b_cls_r;
  rbb_pix_t      rd_up2_r, rd_up1_r;
  logic          fwd_r;
  rbb_pix_t      fwd_up2_r, fwd_up1_r;
  rbb_pix_t      up2_b, up1_b;

  rbb_pix_t      win_r [9];
  logic          c_vld_r;
  rbb_cls_t      c_cls_r;

  logic                d_vld_r;
  rbb_cls_t            d_cls_r;
  logic [SUM_BITS-1:0] d_sum_red_r, d_sum_grn_r, d_sum_blu_r;
  rbb_pix_t            d_ctr_r;

  logic [SUM_BITS-1:0] sum_red, sum_grn, sum_blu;
  rbb_pix_t            mean_pix;

  logic                out_valid_r;
  rbb_pix_t            out_pix_r;
  logic                out_last_r;

  function automatic logic [7:0] mean9(input logic [SUM_BITS-1:0] s);
    logic [SUM_BITS+RECIP_BITS-1:0] prod;
    prod = (SUM_BITS+RECIP_BITS)'(s) * (SUM_BITS+RECIP_BITS)'(MEAN_RECIP);
    return prod[MEAN_SHIFT +: 8];
  endfunction

  assign adv     = !out_valid_r || out_ready;
  assign pop     = adv && q_valid;
  assign q_ready = adv;

  // width-1 images hit the same column on consecutive transactions
  assign up1_b = fwd_r ? fwd_up1_r : rd_up1_r;
  assign up2_b = fwd_r ? fwd_up2_r : rd_up2_r;

  always_ff @(posedge clk) begin
    if (adv && b_vld_r) begin
      older_row_r[b_col_r] <= up1_b;
      newer_row_r[b_col_r] <= b_pix_r;
    end
    if (pop) begin
      rd_up2_r <= older_row_r[q_col];
      rd_up1_r <= newer_row_r[q_col];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_col_r   <= q_col;
      b_pix_r   <= q_pix;
      b_cls_r   <= q_cls;
      fwd_r     <= b_vld_r && (b_col_r == q_col);
      fwd_up1_r <= b_pix_r;
      fwd_up2_r <= up1_b;
    end
    if (adv) begin
      c_cls_r     <= b_cls_r;
      d_cls_r     <= c_cls_r;
      d_sum_red_r <= sum_red;
      d_sum_grn_r <= sum_grn;
      d_sum_blu_r <= sum_blu;
      d_ctr_r     <= win_r[4];
      out_pix_r   <= d_cls_r.inner ? mean_pix : d_ctr_r;
      out_last_r  <= d_cls_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (adv && b_vld_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]     <= win_r[r*3 + 1];
        win_r[r*3 + 1] <= win_r[r*3 + 2];
      end
      win_r[2] <= up2_b;
      win_r[5] <= up1_b;
      win_r[8] <= b_pix_r;
    end
  end

  always_comb begin
    sum_red = '0;
    sum_grn = '0;
    sum_blu = '0;
    for (int i = 0; i < 9; i++) begin
      sum_red = sum_red + SUM_BITS'(win_r[i].red);
      sum_grn = sum_grn + SUM_BITS'(win_r[i].green);
      sum_blu = sum_blu + SUM_BITS'(win_r[i].blue);
    end
  end

  assign mean_pix = '{red:   mean9(d_sum_red_r),
                      green: mean9(d_sum_grn_r),
                      blue:  mean9(d_sum_blu_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r     <= 1'b0;
      c_vld_r     <= 1'b0;
      d_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b_vld_r     <= pop;
      c_vld_r     <= b_vld_r;
      d_vld_r     <= c_vld_r;
      out_valid_r <= d_vld_r && d_cls_r.emit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = out_pix_r.red;
  assign out_green_out  = out_pix_r.green;
  assign out_blue_out   = out_pix_r.blue;
  assign out_last_pixel = out_last_r;

endmodule

// ===== rtl/core/rgb_box_blur_3x3.sv =====
// Top level of the streaming RGB 3x3 box blur.
// Raster-order RGB 3x3 mean filter, one pixel per clock unless back-pressured or held off.
// Each result is the truncated per-channel mean of the nine original neighbors; first/last
// rows and columns pass through. Results trail input by image_width+1 transactions, so send
// image_width+1 flush transactions after the image; the final result carries out_last_pixel.
// Inputs pass through the queue, line-store read, window and sum registers, and the mean
// multiply sits in front of the output register. After reset and after every config write
// the input is held off while a one-bit-per-clock divider rederives the output row/column
// from the transaction count. Config writes are taken on any clock but belong
// between images or while the block is idle.
module rgb_box_blur_3x3 import rbb_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_red_in,
  input  logic [7:0]        in_green_in,
  input  logic [7:0]        in_blue_in,
  input  logic              in_flush,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_red_out,
  output logic [7:0]        out_green_out,
  output logic [7:0]        out_blue_out,
  output logic              out_last_pixel
);

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int DW = CB + PIX_BITS + CLS_BITS;

  logic          push_valid, push_ready;
  logic [CB-1:0] push_col;
  rbb_pix_t      push_pix;
  rbb_cls_t      push_cls;
  logic          q_valid, q_ready;
  logic [DW-1:0] q_data;
  logic [CB-1:0] q_col;
  rbb_pix_t      q_pix;
  rbb_cls_t      q_cls;

  rbb_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_red_in   (in_red_in),
    .in_green_in (in_green_in),
    .in_blue_in  (in_blue_in),
    .in_flush    (in_flush),
    .q_ready     (push_ready),
    .push_valid  (push_valid),
    .push_col    (push_col),
    .push_pix    (push_pix),
    .push_cls    (push_cls)
  );

  rbb_queue #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_col, push_pix, push_cls}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_col = q_data[DW-1 -: CB];
  assign q_pix = q_data[CLS_BITS +: PIX_BITS];
  assign q_cls = q_data[CLS_BITS-1:0];

  rbb_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_col          (q_col),
    .q_pix          (q_pix),
    .q_cls          (q_cls),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_last_pixel (out_last_pixel)
  );

endmodule

// ===== tb/box_blur_checker.sv =====
// Scoreboard for the RGB 3x3 box blur: mirrors the filter and checks every output transaction.
module box_blur_checker import rbb_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [7:0]        in_red_in,
  input  logic [7:0]        in_green_in,
  input  logic [7:0]        in_blue_in,
  input  logic              in_flush,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [7:0]        out_red_out,
  input  logic [7:0]        out_green_out,
  input  logic [7:0]        out_blue_out,
  input  logic              out_last_pixel,
  output int                fail_count,
  output int                pending_results
);

  localparam int TAPS         = 9;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    rbb_pix_t pix;
    logic     last;
  } blur_out_t;

  rbb_pix_t             older_row [MAX_WIDTH];
  rbb_pix_t             newer_row [MAX_WIDTH];
  rbb_pix_t             win [TAPS];
  logic [WREG_BITS-1:0] width_reg;
  logic [HREG_BITS-1:0] height_reg;
  int unsigned          col_pos;
  logic [K_BITS-1:0]    items_in;
  blur_out_t            blur_expect_q [$];
  int                   error_total;

  function automatic rbb_pix_t window_mean();
    int unsigned sr;
    int unsigned sg;
    int unsigned sb;
    rbb_pix_t    m;
    sr = 0;
    sg = 0;
    sb = 0;
    for (int i = 0; i < TAPS; i++) begin
      sr += 32'(win[i].red);
      sg += 32'(win[i].green);
      sb += 32'(win[i].blue);
    end
    m.red   = 8'(sr / TAPS);
    m.green = 8'(sg / TAPS);
    m.blue  = 8'(sb / TAPS);
    return m;
  endfunction

  task automatic reset_blur();
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (int i = 0; i < TAPS; i++) win[i] = '0;
    col_pos  = 0;
    items_in = '0;
    blur_expect_q.delete();
    error_total = 0;
  endtask

  // advance the filter by one input transaction, queue the output it produces
  task automatic blur_step(input rbb_pix_t pix_in, input logic drain);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned k;
    int unsigned col;
    int unsigned p;
    int unsigned pr;
    int unsigned pc;
    rbb_pix_t    pix;
    rbb_pix_t    up2;
    rbb_pix_t    up1;
    blur_out_t   res;
    w = 32'(width_reg);
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = 32'(height_reg);
    if (h == 0) h = 1;
    total = w * h;
    if (col_pos >= w) col_pos = 0;
    col = col_pos;
    k   = 32'(items_in);
    pix = (k < total && !drain) ? pix_in : '0;
    up2 = older_row[col];
    up1 = newer_row[col];
    older_row[col] = up1;
    newer_row[col] = pix;
    for (int r = 0; r < 3; r++) begin
      win[r*3]   = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = pix;
    if (k >= w + 1 && k - (w + 1) < total) begin
      p  = k - (w + 1);
      pr = p / w;
      pc = p % w;
      if (pr >= 1 && pr + 2 <= h && pc >= 1 && pc + 2 <= w) res.pix = window_mean();
      else res.pix = win[4];
      res.last = (p == total - 1);
      blur_expect_q.push_back(res);
    end
    if (k >= total + w) begin
      items_in = '0;
      col_pos  = 0;
    end else begin
      items_in = items_in + K_BITS'(1);
      col_pos  = (col + 1 >= w) ? 0 : col + 1;
    end
  endtask

  always @(posedge clk) begin : watch
    blur_out_t got;
    blur_out_t want;
    if (!rst_n) begin
      reset_blur();
    end else begin
      if (out_valid && out_ready) begin
        got.pix  = {out_red_out, out_green_out, out_blue_out};
        got.last = out_last_pixel;
        if (blur_expect_q.size() == 0) begin
          error_total++;
          if (error_total <= REPORT_LIMIT)
            $display("unexpected output: r=%0d g=%0d b=%0d last=%0b",
                     got.pix.red, got.pix.green, got.pix.blue, got.last);
        end else begin
          want = blur_expect_q.pop_front();
          if (got.pix.red !== want.pix.red || got.pix.green !== want.pix.green ||
              got.pix.blue !== want.pix.blue || got.last !== want.last) begin
            error_total++;
            if (error_total <= REPORT_LIMIT)
              $display("mismatch: exp r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                       want.pix.red, want.pix.green, want.pix.blue, want.last,
                       got.pix.red, got.pix.green, got.pix.blue, got.last);
          end
        end
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_IDX_WIDTH) width_reg = cfg_wdata[WREG_BITS-1:0];
        else if (cfg_idx == CFG_IDX_HEIGHT) height_reg = cfg_wdata[HREG_BITS-1:0];
      end
      if (in_valid && in_ready)
        blur_step({in_red_in, in_green_in, in_blue_in}, in_flush);
    end
    fail_count      <= error_total;
    pending_results <= blur_expect_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the RGB 3x3 box blur regression: clock, reset, stimulus and verdict.
module testbench;
  import rbb_pkg::*;

  localparam int RANDOM_ITEMS  = 1900;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 3_000_000;

  logic              clk;
  logic              rst_n         = 1'b0;
  logic              cfg_we        = 1'b0;
  logic [CFG_IW-1:0] cfg_idx       = CFG_IDX_WIDTH;
  logic [CFG_DW-1:0] cfg_wdata     = '0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic [7:0]        in_red_in     = '0;
  logic [7:0]        in_green_in   = '0;
  logic [7:0]        in_blue_in    = '0;
  logic              in_flush      = 1'b0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [7:0]        out_red_out;
  logic [7:0]        out_green_out;
  logic [7:0]        out_blue_out;
  logic              out_last_pixel;
  int                fail_count;
  int                pending_results;
  int unsigned       cur_w;
  int unsigned       cur_h;
  int unsigned       cycles;
  int unsigned       rx_hold;
  int unsigned       rx_pick;
  bit                tx_calm;
  bit                rx_calm;

  rgb_box_blur_3x3 u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .in_flush      (in_flush),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_last_pixel(out_last_pixel)
  );

  box_blur_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_flush       (in_flush),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_last_pixel (out_last_pixel),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // result side: random backpressure, with calm stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold = 0;
    end else begin
      if ($urandom_range(0, 299) == 0) rx_calm = !rx_calm;
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_calm) begin
          rx_pick = $urandom_range(0, 99);
          if (rx_pick < 25) rx_hold = $urandom_range(1, 3);
          else if (rx_pick < 28) rx_hold = $urandom_range(10, 30);
        end
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic flush);
    int unsigned gap;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    in_flush    <= flush;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // geometry writes happen only with the block drained and settled
  task automatic set_geometry(input logic [CFG_DW-1:0] wv, input logic [CFG_DW-1:0] hv);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_IDX_WIDTH;
    cfg_wdata <= wv;
    @(posedge clk);
    cfg_idx   <= CFG_IDX_HEIGHT;
    cfg_wdata <= hv;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_w = 32'(wv[WREG_BITS-1:0]);
    if (cur_w == 0) cur_w = 1;
    if (cur_w > MAX_WIDTH_DEF) cur_w = MAX_WIDTH_DEF;
    cur_h = 32'(hv[HREG_BITS-1:0]);
    if (cur_h == 0) cur_h = 1;
  endtask

  // one full frame plus its drain; noisy frames mix in black and ignored transactions
  task automatic send_image(input bit noisy);
    int unsigned npix;
    npix    = cur_w * cur_h;
    tx_calm = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < npix; i++) begin
      if ($urandom_range(0, 255) == 0) wait_drained();
      push_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                 noisy && $urandom_range(0, 15) == 0);
    end
    for (int unsigned i = 0; i <= cur_w; i++)
      push_pixel(8'($urandom), 8'($urandom), 8'($urandom),
                 !(noisy && $urandom_range(0, 7) == 0));
  endtask

  initial begin
    int unsigned small_items;
    int unsigned img;
    int unsigned wv;
    int unsigned hv;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // 3x3 of full-scale pixels: one interior mean at its maximum, pause mid-frame,
    // a real pixel inside the drain is ignored
    set_geometry(12'd3, 12'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 6) wait_drained();
      push_pixel(8'hff, 8'hff, 8'hff, 1'b0);
    end
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'h5a, 8'ha5, 8'h3c, 1'b0);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);

    // zero width and height fall back to 1x1; a flush inside the frame is black
    set_geometry(12'h800, 12'd0);
    push_pixel(8'h12, 8'h34, 8'h56, 1'b1);
    push_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);

    small_items = 0;
    img = 0;
    while (small_items < RANDOM_ITEMS) begin
      if (img == 2) begin
        set_geometry(12'h7ff, 12'd1);
        send_image(1'b1);
      end else if (img == 1) begin
        set_geometry(12'd1, 12'd96);
        send_image(1'b1);
      end else begin
        wv = ($urandom_range(0, 6) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        hv = ($urandom_range(0, 6) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
        set_geometry({1'($urandom_range(0, 1)), 11'(wv)}, 12'(hv));
        send_image(1'b1);
      end
      small_items += cur_w * cur_h + cur_w + 1;
      img++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/rbb_pkg.sv
rtl/core/rbb_front.sv
rtl/core/rbb_queue.sv
rtl/core/rbb_back.sv
rtl/core/rgb_box_blur_3x3.sv
tb/box_blur_checker.sv
tb/testbench.sv
